>>> src/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// Shared sizes, request and status codes and the cell control word for the
// positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

  // list geometry
  localparam int DEPTH  = 128;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  // compare width wide enough for both position and count plus one
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // control word broadcast to every cell
  typedef struct packed {
    logic              upd_ins;
    logic              upd_del;
    logic [IDX_W-1:0]  sel;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> src/plst_cell.sv
// ----------------------------------------------------------------------------
// plst_cell
// One list slot: holds a word, shifts up or down with its neighbours on
// insert and delete, and passes the read word along the read chain.
// ----------------------------------------------------------------------------
module plst_cell
  import plst_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  input  logic [WORD_W-1:0] rd_in,
  output logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] rd_out
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [WORD_W-1:0] rd_r;
  logic [WORD_W-1:0] rd_nxt;
  logic              hit;
  logic              above;

  assign hit   = (cell_idx == ctrl.sel);
  assign above = (cell_idx > ctrl.sel);

  // slot update on insert and delete
  always_comb begin
    word_nxt = word_r;
    if (ctrl.upd_ins) begin
      if (above) begin
        word_nxt = left_word;
      end else if (hit) begin
        word_nxt = ctrl.value;
      end
    end else if (ctrl.upd_del) begin
      if (hit || above) begin
        word_nxt = right_word;
      end
    end
  end

  // read chain: the selected slot injects its word, others pass it down
  assign rd_nxt = hit ? word_r : rd_in;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rd_r   <= rd_nxt;
  end

  assign word   = word_r;
  assign rd_out = rd_r;

endmodule

>>> src/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of signed words addressed by one-based position.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream: in_tuser carries the kind (insert,
// delete, get, clear), in_tdata the position and the insert word. Each
// request gives exactly one word on the out_ stream with status, the read
// or removed word and the list length after the request.
// The list lives in a row of cells; insert and delete shift every cell in
// parallel. A read travels down a registered chain from the selected cell
// to cell zero, one cell per cycle.
// Insert, clear and any error need no walk of the read chain; a good get
// or delete first waits for the read chain to bring the word to cell
// zero. One request is in work at a time, so the next is taken once the
// result has been placed in the output register.
// A stalled receiver holds the result in the output register; one more
// request may be accepted, but its result waits until the slot is free.
// Reset empties the list (length zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store_core
  import plst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [1:0] status, [33:2] data, [41:34] length
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [1:0]        kind_r;
  logic [1:0]        stat_r;
  logic [IDX_W-1:0]  sel_r;
  logic [WORD_W-1:0] value_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_stat_r;
  logic [WORD_W-1:0] out_data_r;
  logic [7:0]        out_len_r;

  logic              accept;
  logic              fire;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [1:0]        stat_in;
  logic              need_walk;
  logic              req_ok;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] words [DEPTH];
  logic [WORD_W-1:0] rds   [DEPTH];

  assign accept  = in_tvalid && in_tready;
  assign pos_ext = CMP_W'(in_tdata[7:0]);
  assign cnt_ext = CMP_W'(count_r);

  // request check against the current length
  always_comb begin
    stat_in = STAT_OK;
    case (in_tuser)
      KIND_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          stat_in = STAT_BADPOS;
        end else if (count_r == CNT_W'(DEPTH)) begin
          stat_in = STAT_FULL;
        end
      end
      KIND_DELETE, KIND_GET: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          stat_in = STAT_BADPOS;
        end
      end
      default: stat_in = STAT_OK;
    endcase
  end

  assign need_walk = (stat_in == STAT_OK) &&
                     (in_tuser == KIND_DELETE || in_tuser == KIND_GET);

  assign req_ok = (stat_r == STAT_OK);
  assign fire = (state_r == S_EXEC) && (walk_r == '0) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  // cell control
  always_comb begin
    ctrl.upd_ins = fire && req_ok && (kind_r == KIND_INSERT);
    ctrl.upd_del = fire && req_ok && (kind_r == KIND_DELETE);
    ctrl.sel     = sel_r;
    ctrl.value   = value_r;
  end

  // sequencer, length and output slot
  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
          walk_nxt  = need_walk ? CNT_W'(pos_ext) : '0;
        end
      end
      S_EXEC: begin
        if (walk_r != '0) begin
          walk_nxt = walk_r - CNT_W'(1);
        end else if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r == KIND_CLEAR) begin
            count_nxt = '0;
          end else if (req_ok && kind_r == KIND_INSERT) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (req_ok && kind_r == KIND_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_tuser;
      stat_r  <= stat_in;
      sel_r   <= IDX_W'(pos_ext - CMP_W'(1));
      value_r <= in_tdata[39:8];
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (fire) begin
      out_stat_r <= stat_r;
      out_data_r <= (req_ok && (kind_r == KIND_DELETE || kind_r == KIND_GET)) ?
                    rds[0] : '0;
      out_len_r  <= 8'(count_nxt);
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    logic [WORD_W-1:0] rd_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
      assign rd_w    = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
      assign rd_w    = rds[i+1];
    end
    plst_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_word  (left_w),
      .right_word (right_w),
      .rd_in      (rd_w),
      .word       (words[i]),
      .rd_out     (rds[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_len_r, out_data_r, out_stat_r};

endmodule
